@@ rtl/imgchk_pkg.sv @@
// ----------------------------------------------------------------------------
// imgchk_pkg
// Shared types, codes and the CRC-32 byte step for the image header checker.
// ----------------------------------------------------------------------------
package imgchk_pkg;

    localparam int APB_AW      = 3;
    localparam int MAX_FIELD_W = 19;

    localparam logic [31:0]            MAGIC_RESET = 32'h3157_364E;
    localparam logic [MAX_FIELD_W-1:0] MAX_RESET   = MAX_FIELD_W'(448 * 1024);
    localparam logic [31:0]            CRC_INIT    = 32'hFFFF_FFFF;

    // register index, taken from paddr[2]
    localparam logic REG_MAGIC = 1'b0;
    localparam logic REG_MAX   = 1'b1;

    // header byte positions
    localparam logic [3:0] HDR_MAGIC_LAST = 4'd3;
    localparam logic [3:0] HDR_LEN_LAST   = 4'd7;
    localparam logic [3:0] HDR_CRC_LAST   = 4'd11;
    localparam logic [3:0] HDR_LAST       = 4'd15;

    // result status codes
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_SIZE    = 3'd3;
    localparam logic [2:0] ST_CRC     = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;

    typedef struct packed {
        logic [2:0]  status;
        logic        write_enable;
        logic [7:0]  write_data;
        logic [31:0] crc_value;
    } t_res;

    localparam logic [31:0] NIBBLE_TAB [16] = '{
        32'h0000_0000, 32'h1DB7_1064, 32'h3B6E_20C8, 32'h26D9_30AC,
        32'h76DC_4190, 32'h6B6B_51F4, 32'h4DB2_6158, 32'h5005_713C,
        32'hEDB8_8320, 32'hF00F_9344, 32'hD6D6_A3E8, 32'hCB61_B38C,
        32'h9B64_C2B0, 32'h86D3_D2D4, 32'hA00A_E278, 32'hBDBD_F21C
    };

    // reflected CRC-32, one byte as two nibble steps
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        c = (c >> 4) ^ NIBBLE_TAB[c[3:0]];
        c = (c >> 4) ^ NIBBLE_TAB[c[3:0]];
        return c;
    endfunction

endpackage

@@ rtl/image_header_crc32_checker.sv @@
// ----------------------------------------------------------------------------
// image_header_crc32_checker
// Byte-serial image checker: 16-byte header, payload writes, CRC-32 verdict.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | i_valid / o_ready   | i_data_byte, i_start_req
//  out      | o_valid / i_ready   | o_status, o_write_*, o_crc_value,
//           |                     | o_payload_bytes
//  config   | psel/penable/pwrite | paddr, pwdata, prdata, pready (APB)
//
//  One byte per cycle while o_ready is high: parse, CRC step and checks
//  finish in the accept cycle and the result appears in the output register in the next cycle.
//  The single-byte CRC step is done as two nibble lookups.
//  o_ready stays high while the output register is empty or being drained.
//  Synchronous active-low reset; the checker then ignores bytes until a start.
// ----------------------------------------------------------------------------
module image_header_crc32_checker #(
    parameter int OFFSET_BITS = 19
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_start_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_status,
    output logic                          o_write_enable,
    output logic [OFFSET_BITS-1:0]        o_write_offset,
    output logic [7:0]                    o_write_data,
    output logic [31:0]                   o_crc_value,
    output logic [OFFSET_BITS-1:0]        o_payload_bytes,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imgchk_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import imgchk_pkg::*;

    logic                   fire;
    logic                   in_ready;
    logic [31:0]            magic;
    logic [31:0]            max_bytes;
    t_res                   core_res;
    t_res                   out_res;
    logic [OFFSET_BITS-1:0] core_offset;
    logic [OFFSET_BITS-1:0] core_count;

    assign o_ready = in_ready;
    assign fire    = i_valid && in_ready;

    imgchk_cfg #(.OFFSET_BITS(OFFSET_BITS)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_magic     (magic),
        .o_max_bytes (max_bytes)
    );

    imgchk_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_data_byte),
        .i_start_req (i_start_req),
        .i_magic     (magic),
        .i_max_bytes (max_bytes),
        .o_res       (core_res),
        .o_offset    (core_offset),
        .o_count     (core_count)
    );

    imgchk_out #(.OFFSET_BITS(OFFSET_BITS)) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_res      (core_res),
        .i_offset   (core_offset),
        .i_count    (core_count),
        .o_in_ready (in_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res),
        .o_offset   (o_write_offset),
        .o_count    (o_payload_bytes)
    );

    assign o_status       = out_res.status;
    assign o_write_enable = out_res.write_enable;
    assign o_write_data   = out_res.write_data;
    assign o_crc_value    = out_res.crc_value;

endmodule

@@ rtl/imgchk_cfg.sv @@
// ----------------------------------------------------------------------------
// imgchk_cfg
// APB register bank: expected magic word and largest payload length.
// ----------------------------------------------------------------------------
module imgchk_cfg #(
    parameter int OFFSET_BITS = 19
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imgchk_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [31:0]                   o_magic,
    output logic [31:0]                   o_max_bytes
);
    import imgchk_pkg::*;

    localparam int MAXW = (OFFSET_BITS < MAX_FIELD_W) ? OFFSET_BITS : MAX_FIELD_W;

    logic [31:0]     r_magic;
    logic [MAXW-1:0] r_max;
    logic            wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
            r_max   <= MAX_RESET[MAXW-1:0];
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MAGIC: r_magic <= pwdata;
                REG_MAX:   r_max   <= pwdata[MAXW-1:0];
                default:   ;
            endcase
        end
    end

    assign o_magic     = r_magic;
    assign o_max_bytes = {{(32-MAXW){1'b0}}, r_max};

    always_comb begin
        unique case (paddr[2])
            REG_MAGIC: prdata = r_magic;
            REG_MAX:   prdata = o_max_bytes;
            default:   prdata = '0;
        endcase
    end

endmodule

@@ rtl/imgchk_core.sv @@
// ----------------------------------------------------------------------------
// imgchk_core
// Header parser, payload write generation and CRC-32 state, one byte per cycle while bytes fire.
// ----------------------------------------------------------------------------
module imgchk_core #(
    parameter int OFFSET_BITS = 19
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_start_req,
    input  logic [31:0]            i_magic,
    input  logic [31:0]            i_max_bytes,
    output imgchk_pkg::t_res       o_res,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [OFFSET_BITS-1:0] o_count
);
    import imgchk_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    t_phase                 r_phase, n_phase, e_phase;
    logic [3:0]             r_hdr_idx, n_hdr_idx, e_hdr_idx;
    logic [31:0]            r_length, n_length, e_length;
    logic [31:0]            r_exp_crc, n_exp_crc, e_exp_crc;
    logic [31:0]            r_crc, n_crc, e_crc;
    logic [OFFSET_BITS-1:0] r_count, n_count, e_count;

    // a start flag restarts the image at header byte 0
    always_comb begin
        e_phase   = i_start_req ? PH_HEADER : r_phase;
        e_hdr_idx = i_start_req ? 4'd0      : r_hdr_idx;
        e_length  = i_start_req ? 32'd0     : r_length;
        e_exp_crc = i_start_req ? 32'd0     : r_exp_crc;
        e_crc     = i_start_req ? CRC_INIT  : r_crc;
        e_count   = i_start_req ? '0        : r_count;
    end

    always_comb begin
        n_phase            = e_phase;
        n_hdr_idx          = e_hdr_idx;
        n_length           = e_length;
        n_exp_crc          = e_exp_crc;
        n_crc              = e_crc;
        n_count            = e_count;
        o_res.status       = ST_BUSY;
        o_res.write_enable = 1'b0;
        o_res.write_data   = 8'd0;
        o_offset           = '0;

        unique case (e_phase)
            PH_HEADER: begin
                if (e_hdr_idx <= HDR_LEN_LAST) begin
                    n_length = {i_data_byte, e_length[31:8]};
                end else if (e_hdr_idx <= HDR_CRC_LAST) begin
                    n_exp_crc = {i_data_byte, e_exp_crc[31:8]};
                end
                if (e_hdr_idx == HDR_MAGIC_LAST) begin
                    if (n_length != i_magic) begin
                        o_res.status = ST_MAGIC;
                        n_phase      = PH_DONE;
                    end
                    // the word now collects the length
                    n_length = 32'd0;
                end else if (e_hdr_idx == HDR_LEN_LAST) begin
                    if (n_length == 32'd0 || n_length > i_max_bytes) begin
                        o_res.status = ST_SIZE;
                        n_phase      = PH_DONE;
                    end
                end else if (e_hdr_idx == HDR_LAST) begin
                    n_phase = PH_PAYLOAD;
                end
                n_hdr_idx = e_hdr_idx + 4'd1;
            end
            PH_PAYLOAD: begin
                o_res.write_enable = 1'b1;
                o_res.write_data   = i_data_byte;
                o_offset           = e_count;
                n_crc              = crc_byte(e_crc, i_data_byte);
                n_count            = e_count + 1'b1;
                if ({{(32-OFFSET_BITS){1'b0}}, n_count} >= e_length) begin
                    o_res.status = (~n_crc == e_exp_crc) ? ST_OK : ST_CRC;
                    n_phase      = PH_DONE;
                end
            end
            default: begin
                o_res.status = ST_IGNORED;
            end
        endcase

        o_res.crc_value = ~n_crc;
        o_count         = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hdr_idx <= 4'd0;
            r_length  <= 32'd0;
            r_exp_crc <= 32'd0;
            r_crc     <= CRC_INIT;
            r_count   <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_length  <= n_length;
            r_exp_crc <= n_exp_crc;
            r_crc     <= n_crc;
            r_count   <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.write_enable) |->
            (o_res.status == ST_BUSY || o_res.status == ST_OK || o_res.status == ST_CRC))
        else $error("payload write with a header verdict");

    a_ignored_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.status == ST_IGNORED) |=>
            (r_crc == $past(r_crc) && r_count == $past(r_count)))
        else $error("ignored byte changed CRC or count");

    a_verdict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.status != ST_BUSY && o_res.status != ST_IGNORED) |=>
            (r_phase == PH_DONE))
        else $error("verdict did not close the image");

    a_start_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_start_req) |=> (r_phase == PH_HEADER && r_hdr_idx == 4'd1))
        else $error("start did not open a header");
`endif

endmodule

@@ rtl/imgchk_out.sv @@
// ----------------------------------------------------------------------------
// imgchk_out
// Result register with valid/ready; takes a new result while the old one leaves.
// ----------------------------------------------------------------------------
module imgchk_out #(
    parameter int OFFSET_BITS = 19
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  imgchk_pkg::t_res       i_res,
    input  logic [OFFSET_BITS-1:0] i_offset,
    input  logic [OFFSET_BITS-1:0] i_count,
    output logic                   o_in_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    output imgchk_pkg::t_res       o_res,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [OFFSET_BITS-1:0] o_count
);
    import imgchk_pkg::*;

    logic                   r_valid;
    t_res                   r_res;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [OFFSET_BITS-1:0] r_count;

    assign o_in_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res    <= i_res;
            r_offset <= i_offset;
            r_count  <= i_count;
        end
    end

    assign o_valid  = r_valid;
    assign o_res    = r_res;
    assign o_offset = r_offset;
    assign o_count  = r_count;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for image_header_crc32_checker.
// Streams images byte by byte: well-formed ones with random payloads, and
// ones with a bad magic, a bad length, a wrong CRC, or a restart partway.
// Also sends stray bytes. An in-bench model of the header parser and the
// CRC-32 predicts every result, and each result is compared field by field.
// Both handshake sides stall at random. The magic and max-length registers
// go through several settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import imgchk_pkg::*;

    localparam int          OFF_W          = 19;
    localparam logic [31:0] MAGIC_AT_RESET = 32'h3157_364E;
    localparam logic [18:0] MAX_AT_RESET   = 19'd458752;
    localparam logic [31:0] CRC_SEED       = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic        APB_WR         = 1'b1;
    localparam logic        APB_RD         = 1'b0;

    typedef enum logic [1:0] {IMG_IDLE, IMG_HEADER, IMG_PAYLOAD, IMG_DONE} t_img_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_byte_item;

    typedef struct packed {
        logic [2:0]       status;
        logic             write_enable;
        logic [OFF_W-1:0] write_offset;
        logic [7:0]       write_data;
        logic [31:0]      crc_value;
        logic [OFF_W-1:0] payload_bytes;
    } t_verdict;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [7:0]              i_data_byte = '0;
    logic                    i_start_req = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [2:0]              o_status;
    logic                    o_write_enable;
    logic [OFF_W-1:0]        o_write_offset;
    logic [7:0]              o_write_data;
    logic [31:0]             o_crc_value;
    logic [OFF_W-1:0]        o_payload_bytes;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_AW-1:0]       paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    image_header_crc32_checker #(
        .OFFSET_BITS(OFF_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_start_req    (i_start_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_write_enable (o_write_enable),
        .o_write_offset (o_write_offset),
        .o_write_data   (o_write_data),
        .o_crc_value    (o_crc_value),
        .o_payload_bytes(o_payload_bytes),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // stimulus and expected results
    t_byte_item  bytes_to_send[$];
    t_verdict    verdicts_due[$];
    int          pushed_count = 0;
    int          accepted_count = 0;
    int          err_count = 0;
    int          tally[8] = '{default: 0};
    int          n_settings = 0;
    bit          steady = 1'b0;

    // handshake bookkeeping
    logic        in_fire = 1'b0;
    logic        out_fire = 1'b0;
    int          send_gap = 0;
    int          take_wait = 0;
    t_byte_item  next_item;
    t_verdict    seen_res;
    t_verdict    due_res;

    // checker model state
    logic [31:0]      cfg_magic = MAGIC_AT_RESET;
    logic [18:0]      cfg_max = MAX_AT_RESET;
    t_img_phase       img_phase = IMG_IDLE;
    logic [3:0]       hdr_pos = '0;
    logic [31:0]      len_word = '0;
    logic [31:0]      hdr_crc = '0;
    logic [31:0]      crc_run = CRC_SEED;
    logic [OFF_W-1:0] pay_count = '0;

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 50) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // reflected CRC-32, one bit at a time
    function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // advances the model by one byte and returns the result it owes
    function automatic t_verdict step_image(input logic [7:0] b, input logic start);
        t_verdict   r;
        logic [3:0] idx;
        r = '0;
        r.status = ST_BUSY;
        if (start) begin
            img_phase = IMG_HEADER;
            hdr_pos   = '0;
            len_word  = '0;
            hdr_crc   = '0;
            crc_run   = CRC_SEED;
            pay_count = '0;
        end
        idx = hdr_pos;
        case (img_phase)
            IMG_HEADER: begin
                // magic then length share one shift register
                if (idx <= HDR_LEN_LAST) len_word = {b, len_word[31:8]};
                else if (idx <= HDR_CRC_LAST) hdr_crc = {b, hdr_crc[31:8]};
                if (idx == HDR_MAGIC_LAST) begin
                    if (len_word != cfg_magic) begin
                        r.status  = ST_MAGIC;
                        img_phase = IMG_DONE;
                    end
                    len_word = '0;
                end else if (idx == HDR_LEN_LAST) begin
                    if (len_word == '0 || len_word > {13'd0, cfg_max}) begin
                        r.status  = ST_SIZE;
                        img_phase = IMG_DONE;
                    end
                end else if (idx == HDR_LAST) begin
                    img_phase = IMG_PAYLOAD;
                end
                hdr_pos = idx + 4'd1;
            end
            IMG_PAYLOAD: begin
                r.write_enable = 1'b1;
                r.write_offset = pay_count;
                r.write_data   = b;
                crc_run   = crc_feed(crc_run, b);
                pay_count = pay_count + 1'b1;
                if ({13'd0, pay_count} >= len_word) begin
                    r.status  = ((~crc_run) == hdr_crc) ? ST_OK : ST_CRC;
                    img_phase = IMG_DONE;
                end
            end
            default: r.status = ST_IGNORED;
        endcase
        r.crc_value     = ~crc_run;
        r.payload_bytes = pay_count;
        return r;
    endfunction

    // sender: holds each item until taken, then waits its drawn gap
    always @(negedge i_clk) begin
        if (i_valid && !in_fire) begin
            // still waiting for o_ready
        end else if (send_gap != 0) begin
            i_valid <= 1'b0;
            send_gap--;
        end else if (bytes_to_send.size() != 0) begin
            next_item   = bytes_to_send.pop_front();
            i_data_byte <= next_item.data;
            i_start_req <= next_item.start;
            i_valid     <= 1'b1;
            send_gap    = steady ? 0 : $urandom_range(0, 5);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: stalls a drawn number of cycles after each result
    always @(negedge i_clk) begin
        if (out_fire) take_wait = steady ? 0 : $urandom_range(0, 5);
        if (take_wait != 0) begin
            i_ready <= 1'b0;
            take_wait--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && i_valid && o_ready;
        out_fire <= i_rst_n && o_valid && i_ready;
        if (i_rst_n) begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_MAGIC) cfg_magic = pwdata;
                    else cfg_max = pwdata[18:0];
                end else if (prdata !== ((paddr[2] == REG_MAX) ? {13'd0, cfg_max} : cfg_magic)) begin
                    report_mismatch($sformatf("register read at %0d gave %h", paddr, prdata));
                end
            end
            // compare before pushing: this edge's item cannot have a result yet
            if (o_valid && i_ready) begin
                seen_res = {o_status, o_write_enable, o_write_offset, o_write_data,
                            o_crc_value, o_payload_bytes};
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result with no item waiting");
                end else begin
                    due_res = verdicts_due.pop_front();
                    if (seen_res.status !== due_res.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  seen_res.status, due_res.status));
                    if (seen_res.write_enable !== due_res.write_enable)
                        report_mismatch($sformatf("write_enable %0d, want %0d",
                                                  seen_res.write_enable, due_res.write_enable));
                    if (seen_res.write_offset !== due_res.write_offset)
                        report_mismatch($sformatf("write_offset %0d, want %0d",
                                                  seen_res.write_offset, due_res.write_offset));
                    if (seen_res.write_data !== due_res.write_data)
                        report_mismatch($sformatf("write_data %h, want %h",
                                                  seen_res.write_data, due_res.write_data));
                    if (seen_res.crc_value !== due_res.crc_value)
                        report_mismatch($sformatf("crc_value %h, want %h",
                                                  seen_res.crc_value, due_res.crc_value));
                    if (seen_res.payload_bytes !== due_res.payload_bytes)
                        report_mismatch($sformatf("payload_bytes %0d, want %0d",
                                                  seen_res.payload_bytes, due_res.payload_bytes));
                end
            end
            if (i_valid && o_ready) begin
                due_res = step_image(i_data_byte, i_start_req);
                verdicts_due.push_back(due_res);
                tally[due_res.status]++;
                accepted_count++;
            end
        end
    end

    task automatic add_byte(input logic [7:0] data, input logic start);
        bytes_to_send.push_back('{data: data, start: start});
        pushed_count++;
    endtask

    // first 'keep' header bytes, little-endian words, start on byte 0
    task automatic add_header(input logic [31:0] mg, input logic [31:0] len,
                              input logic [31:0] crc, input logic [31:0] rsvd, input int keep);
        logic [127:0] hdr;
        hdr = {rsvd, crc, len, mg};
        for (int k = 0; k < keep && k < 16; k++) add_byte(hdr[8*k +: 8], k == 0);
    endtask

    // image cut after 'keep' bytes; the header CRC covers the bytes actually sent
    task automatic add_image(input logic [31:0] mg, input logic [31:0] len,
                             input bit corrupt, input int keep);
        logic [7:0]  body[$];
        logic [31:0] c;
        int          n;
        n = (keep > 16) ? keep - 16 : 0;
        c = CRC_SEED;
        for (int k = 0; k < n; k++) begin
            body.push_back(8'($urandom_range(0, 255)));
            c = crc_feed(c, body[k]);
        end
        c = ~c;
        if (corrupt) c ^= 32'h1 << $urandom_range(0, 31);
        add_header(mg, len, c, $urandom(), keep);
        for (int k = 0; k < n; k++) add_byte(body[k], 1'b0);
    endtask

    // mostly well-formed images, the rest broken sequences and stray bytes
    task automatic gen_traffic(input int budget, input logic [31:0] mg, input logic [18:0] mx);
        int          used;
        int          cap;
        int          kind;
        int          n;
        logic [31:0] len;
        used = 0;
        cap  = (mx == '0) ? 1 : ((mx < 19'd48) ? int'(mx) : 48);
        while (used < budget) begin
            len  = $urandom_range(1, cap);
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                add_image(mg, len, $urandom_range(0, 3) == 0, 16 + len);
                used += 16 + len;
            end else if (kind < 14) begin
                add_image($urandom_range(0, 1) ? (mg ^ (32'h1 << $urandom_range(0, 31)))
                                               : 32'($urandom()),
                          len, 1'b0, 4 + $urandom_range(0, 3));
                used += 4;
            end else if (kind < 16) begin
                case ($urandom_range(0, 3))
                    0:       len = '0;
                    1:       len = {13'd0, mx} + 32'd1;
                    2:       len = 32'hFFFF_FFFF;
                    default: len = $urandom() | 32'h8000_0000;
                endcase
                add_image(mg, len, 1'b0, 8);
                used += 8;
            end else if (kind < 19) begin
                // the next start cuts this one short
                n = $urandom_range(1, 15 + len);
                add_image(mg, len, 1'b0, n);
                used += n;
            end else begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)),
                                                       $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // wait until every byte is taken and every result is back
    task automatic quiesce();
        int spent;
        spent = 0;
        while ((accepted_count != pushed_count || verdicts_due.size() != 0) && spent < 20000) begin
            @(negedge i_clk);
            spent++;
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // new settings, length limit probed at and just past the max, then random traffic
    task automatic run_phase(input logic [31:0] mg, input logic [18:0] mx,
                             input bit quiet, input int budget);
        apb_access(APB_WR, REG_MAGIC, mg);
        apb_access(APB_RD, REG_MAGIC, '0);
        apb_access(APB_WR, REG_MAX, {13'd0, mx});
        apb_access(APB_RD, REG_MAX, '0);
        n_settings++;
        steady = quiet;
        add_image(mg, {13'd0, mx}, 1'b0, (mx <= 19'd64) ? 16 + int'(mx) : 19);
        add_image(mg, {13'd0, mx} + 32'd1, 1'b0, 8);
        gen_traffic(budget, mg, mx);
        quiesce();
        steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_access(APB_RD, REG_MAGIC, '0);
        apb_access(APB_RD, REG_MAX, '0);

        // stray byte before any start
        add_byte(8'hFF, 1'b0);
        // one-byte image, all-ones payload and reserved word
        add_header(MAGIC_AT_RESET, 32'd1, ~crc_feed(CRC_SEED, 8'hFF), 32'hFFFF_FFFF, 16);
        add_byte(8'hFF, 1'b0);
        // byte after the verdict
        add_byte(8'h00, 1'b0);
        // magic off in its top bit
        add_image(MAGIC_AT_RESET ^ 32'h8000_0000, 32'd1, 1'b0, 4);
        quiesce();

        // reset settings: largest length accepted then cut, one more rejected
        add_image(MAGIC_AT_RESET, {13'd0, MAX_AT_RESET}, 1'b0, 19);
        add_image(MAGIC_AT_RESET, {13'd0, MAX_AT_RESET} + 32'd1, 1'b0, 8);
        gen_traffic(130, MAGIC_AT_RESET, MAX_AT_RESET);
        quiesce();

        run_phase($urandom(), 19'($urandom_range(16, 64)), 1'b1, 140);
        run_phase(32'h0000_0000, 19'd0, 1'b0, 80);
        run_phase(32'hFFFF_FFFF, 19'd1, 1'b0, 120);
        run_phase($urandom(), MAX_AT_RESET, 1'b0, 140);
        run_phase(MAGIC_AT_RESET, 19'($urandom_range(1, 48)), 1'b0, 110);

        if (accepted_count != pushed_count || verdicts_due.size() != 0)
            report_mismatch($sformatf("%0d items unsent, %0d results missing",
                                      pushed_count - accepted_count, verdicts_due.size()));

        $display("%0d bytes checked: %0d ok, %0d bad magic, %0d bad size, %0d crc mismatch,",
                 accepted_count, tally[ST_OK], tally[ST_MAGIC], tally[ST_SIZE], tally[ST_CRC]);
        $display("%0d ignored, %0d in progress; %0d register settings incl. zero and max",
                 tally[ST_IGNORED], tally[ST_BUSY], n_settings + 1);
        if (err_count == 0) begin
            $display("image_header_crc32_checker verification clean");
        end else begin
            $display("image_header_crc32_checker verification failed");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("timeout");
        $display("image_header_crc32_checker verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/imgchk_pkg.sv
rtl/imgchk_cfg.sv
rtl/imgchk_core.sv
rtl/imgchk_out.sv
rtl/image_header_crc32_checker.sv
verif/testbench.sv
